@@ src/dmt_pkg.sv @@
// dmt_pkg: shared types and constants for the maximal munch dfa tokenizer
// no dependencies
package dmt_pkg;

  localparam int CMD_W   = 2;
  localparam int STATE_W = 6;
  localparam int SYM_W   = 7;
  localparam int KIND_W  = 2;

  localparam logic [CMD_W-1:0] CMD_SET_TRANS  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET_ACCEPT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SCAN       = 2'd2;
  localparam logic [CMD_W-1:0] CMD_END        = 2'd3;

  localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

  typedef struct packed {
    logic               valid;
    logic [STATE_W-1:0] target;
  } tbl_entry_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SYM_W-1:0]  sym;
  } out_item_t;

  typedef struct packed {
    logic tbl_we;
    logic tbl_re;
    logic acc_we;
    logic acc_re;
  } mem_ctl_t;

endpackage

@@ src/dfa_maximal_munch_tokenizer_core.sv @@
// a load is written as it is accepted; a scan or end-of-word result enters the
// output queue from the look state, the second result of a token boundary
// retry from the retry state, each held while the queue is full; no new item
// is taken until those results are queued; loads one per cycle while idle
// reset: a clearing pass writes all 2**(log2 states + log2 alphabet) transition
// entries (8192 by default), no item accepted, config writes taken
module dfa_maximal_munch_tokenizer_core
  import dmt_pkg::*;
#(
  parameter int NUM_STATES = 64,
  parameter int ALPHABET_SIZE = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [STATE_W-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   command,
  input  logic [STATE_W-1:0] state_index,
  input  logic [SYM_W-1:0]   symbol,
  input  logic [STATE_W-1:0] target_state,
  input  logic               flag,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [KIND_W-1:0]  kind,
  output logic [SYM_W-1:0]   out_symbol
);

  localparam int SW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int ADDR_W = SW + AW;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;
  localparam logic [1:0] S_RETRY = 2'd3;

  logic [1:0]         state, state_next;
  logic [ADDR_W-1:0]  clr_addr;
  logic [STATE_W-1:0] cur_state, cur_state_next;
  logic               token_empty, token_empty_next;
  logic               error_seen, error_seen_next;
  logic [STATE_W-1:0] home_state;
  logic [CMD_W-1:0]   cmd_r;
  logic [SYM_W-1:0]   sym_r;

  mem_ctl_t           mem_ctl;
  logic [ADDR_W-1:0]  tbl_waddr, tbl_raddr;
  tbl_entry_t         tbl_wdata, tbl_rdata;
  logic [SW-1:0]      acc_waddr;
  logic               acc_wdata, acc_rdata;

  logic               push, fifo_full;
  out_item_t          push_item, out_item;

  logic in_acc, sidx_ok, in_sym_ok, cur_ok, sym_r_ok, hit, acc;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;

  assign sidx_ok   = (32'(state_index) < NUM_STATES);
  assign in_sym_ok = (32'(symbol) < ALPHABET_SIZE);
  assign cur_ok    = (32'(cur_state) < NUM_STATES);
  assign sym_r_ok  = (32'(sym_r) < ALPHABET_SIZE);
  assign hit       = tbl_rdata.valid && cur_ok && sym_r_ok;
  assign acc       = acc_rdata && cur_ok;

  always_comb begin
    mem_ctl          = '0;
    tbl_waddr        = {SW'(state_index), AW'(symbol)};
    tbl_wdata        = flag ? tbl_entry_t'{valid: 1'b1, target: target_state} : '0;
    tbl_raddr        = {SW'(cur_state), AW'(symbol)};
    acc_waddr        = SW'(state_index);
    acc_wdata        = flag;
    push             = 1'b0;
    push_item        = '{kind: KIND_ERROR, sym: '0};
    state_next       = state;
    cur_state_next   = cur_state;
    token_empty_next = token_empty;
    error_seen_next  = error_seen;
    case (state)
      S_CLEAR: begin
        mem_ctl.tbl_we = 1'b1;
        mem_ctl.acc_we = 1'b1;
        tbl_waddr      = clr_addr;
        tbl_wdata      = '0;
        acc_waddr      = clr_addr[ADDR_W-1 -: SW];
        acc_wdata      = 1'b0;
        if (&clr_addr) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          case (command)
            CMD_SET_TRANS: begin
              mem_ctl.tbl_we = sidx_ok && in_sym_ok;
            end
            CMD_SET_ACCEPT: begin
              mem_ctl.acc_we = sidx_ok;
            end
            default: begin
              mem_ctl.tbl_re = 1'b1;
              mem_ctl.acc_re = 1'b1;
              state_next     = S_LOOK;
            end
          endcase
        end
      end
      S_LOOK: begin
        if (!fifo_full) begin
          push       = 1'b1;
          state_next = S_IDLE;
          if (error_seen) begin
            push_item.kind = KIND_ERROR;
          end else if (cmd_r == CMD_END) begin
            if (acc) begin
              push_item.kind   = KIND_END;
              cur_state_next   = home_state;
              token_empty_next = 1'b1;
            end else begin
              error_seen_next = 1'b1;
            end
          end else if (hit) begin
            push_item        = '{kind: KIND_CHAR, sym: sym_r};
            cur_state_next   = tbl_rdata.target;
            token_empty_next = 1'b0;
          end else if (token_empty || !acc) begin
            error_seen_next = 1'b1;
          end else begin
            push_item.kind   = KIND_END;
            cur_state_next   = home_state;
            token_empty_next = 1'b1;
            mem_ctl.tbl_re   = 1'b1;
            tbl_raddr        = {SW'(home_state), AW'(sym_r)};
            state_next       = S_RETRY;
          end
        end
      end
      S_RETRY: begin
        if (!fifo_full) begin
          push       = 1'b1;
          state_next = S_IDLE;
          if (hit) begin
            push_item        = '{kind: KIND_CHAR, sym: sym_r};
            cur_state_next   = tbl_rdata.target;
            token_empty_next = 1'b0;
          end else begin
            error_seen_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      cur_state   <= '0;
      token_empty <= 1'b1;
      error_seen  <= 1'b0;
      home_state  <= '0;
    end else begin
      state       <= state_next;
      cur_state   <= cur_state_next;
      token_empty <= token_empty_next;
      error_seen  <= error_seen_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (cfg_valid && cfg_ready) begin
        home_state <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= command;
      sym_r <= symbol;
    end
  end

  dmt_state_mem #(
    .ADDR_W (ADDR_W),
    .SADDR_W(SW)
  ) u_mem (
    .clk      (clk),
    .ctl      (mem_ctl),
    .tbl_waddr(tbl_waddr),
    .tbl_wdata(tbl_wdata),
    .tbl_raddr(tbl_raddr),
    .tbl_rdata(tbl_rdata),
    .acc_waddr(acc_waddr),
    .acc_wdata(acc_wdata),
    .acc_raddr(SW'(cur_state)),
    .acc_rdata(acc_rdata)
  );

  dmt_out_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .full     (fifo_full),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  assign kind       = out_item.kind;
  assign out_symbol = out_item.sym;

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !fifo_full)
    else $error("result pushed into a full queue");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    error_seen |=> error_seen)
    else $error("error flag cleared without reset");

  a_char_fills_token: assert property (@(posedge clk) disable iff (rst)
    (push && push_item.kind == KIND_CHAR) |=> !token_empty)
    else $error("token still empty after a character");

  a_no_output_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !out_valid)
    else $error("result presented during clearing pass");

endmodule

@@ src/dmt_state_mem.sv @@
// dmt_state_mem: transition table and accepting mark memories
// one write and one registered read port each; depends on dmt_pkg
module dmt_state_mem
  import dmt_pkg::*;
#(
  parameter int ADDR_W = 13,
  parameter int SADDR_W = 6
) (
  input  logic               clk,
  input  mem_ctl_t           ctl,
  input  logic [ADDR_W-1:0]  tbl_waddr,
  input  tbl_entry_t         tbl_wdata,
  input  logic [ADDR_W-1:0]  tbl_raddr,
  output tbl_entry_t         tbl_rdata,
  input  logic [SADDR_W-1:0] acc_waddr,
  input  logic               acc_wdata,
  input  logic [SADDR_W-1:0] acc_raddr,
  output logic               acc_rdata
);

  tbl_entry_t tbl_mem [2**ADDR_W];
  logic       acc_mem [2**SADDR_W];

  always_ff @(posedge clk) begin
    if (ctl.tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    if (ctl.tbl_re) begin
      tbl_rdata <= tbl_mem[tbl_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    if (ctl.acc_re) begin
      acc_rdata <= acc_mem[acc_raddr];
    end
  end

endmodule

@@ src/dmt_out_fifo.sv @@
// dmt_out_fifo: two-entry result queue in front of the output channel
// depends on dmt_pkg
module dmt_out_fifo
  import dmt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_item_t push_item,
  output logic      full,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  out_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_item  = slots[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push && !full) - 2'(pop);
    end
  end

endmodule

@@ tb/tb_dfa_maximal_munch_tokenizer_core.sv @@
// tb_dfa_maximal_munch_tokenizer_core: self-checking testbench for the maximal munch dfa tokenizer
// builds automata through load transactions, scans well-formed words under varying flow control
// depends on dmt_pkg and dfa_maximal_munch_tokenizer_core
module tb_dfa_maximal_munch_tokenizer_core;
  import dmt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_DEPTH = 1 << (STATE_W + SYM_W);
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 175;

  class munch_tracker;
    tbl_entry_t         trans [TBL_DEPTH];
    bit                 acc [1 << STATE_W];
    logic [STATE_W-1:0] cur;
    logic [STATE_W-1:0] start_st;
    bit                 tok_empty;
    bit                 err_seen;
    out_item_t          pending [$];

    function new();
      foreach (trans[i]) trans[i] = '0;
      foreach (acc[i]) acc[i] = 1'b0;
      cur = '0;
      start_st = '0;
      tok_empty = 1'b1;
      err_seen = 1'b0;
    endfunction

    function void push(logic [KIND_W-1:0] k, logic [SYM_W-1:0] s);
      out_item_t it;
      it.kind = k;
      it.sym = s;
      pending.insert(pending.size(), it);
    endfunction

    function void note_item(logic [CMD_W-1:0] c, logic [STATE_W-1:0] st,
                            logic [SYM_W-1:0] sy, logic [STATE_W-1:0] tg, logic fl);
      tbl_entry_t e;
      if (c == CMD_SET_TRANS) begin
        trans[{st, sy}].valid = fl;
        trans[{st, sy}].target = fl ? tg : '0;
      end else if (c == CMD_SET_ACCEPT) begin
        acc[st] = fl;
      end else if (err_seen) begin
        push(KIND_ERROR, '0);
      end else if (c == CMD_END) begin
        if (acc[cur]) begin
          push(KIND_END, '0);
          cur = start_st;
          tok_empty = 1'b1;
        end else begin
          push(KIND_ERROR, '0);
          err_seen = 1'b1;
        end
      end else begin
        e = trans[{cur, sy}];
        if (!e.valid) begin
          if (tok_empty || !acc[cur]) begin
            push(KIND_ERROR, '0);
            err_seen = 1'b1;
            return;
          end
          push(KIND_END, '0);
          cur = start_st;
          tok_empty = 1'b1;
          e = trans[{cur, sy}];
          if (!e.valid) begin
            push(KIND_ERROR, '0);
            err_seen = 1'b1;
            return;
          end
        end
        push(KIND_CHAR, sy);
        cur = e.target;
        tok_empty = 1'b0;
      end
    endfunction

    function string check_result(logic [KIND_W-1:0] k, logic [SYM_W-1:0] s);
      out_item_t want;
      if (pending.size() == 0)
        return $sformatf("unexpected result kind %0d symbol %0d", k, s);
      want = pending.pop_front();
      if (k !== want.kind)
        return $sformatf("kind %0d, expected %0d", k, want.kind);
      if (s !== want.sym)
        return $sformatf("out_symbol %0d, expected %0d", s, want.sym);
      return "";
    endfunction
  endclass

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [STATE_W-1:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [CMD_W-1:0]   command = '0;
  logic [STATE_W-1:0] state_index = '0;
  logic [SYM_W-1:0]   symbol = '0;
  logic [STATE_W-1:0] target_state = '0;
  logic               flag = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [KIND_W-1:0]  kind;
  logic [SYM_W-1:0]   out_symbol;

  munch_tracker sb = new();
  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  dfa_maximal_munch_tokenizer_core DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .state_index(state_index),
    .symbol(symbol),
    .target_state(target_state),
    .flag(flag),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .out_symbol(out_symbol)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  always @(posedge clk) begin : result_check
    string msg;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      msg = sb.check_result(kind, out_symbol);
      if (msg != "") report_mismatch(msg);
    end
  end

  function automatic logic [STATE_W-1:0] pool_state();
    return {$urandom_range(0, 1) ? 3'b111 : 3'b000, 3'($urandom_range(0, 7))};
  endfunction

  function automatic logic [SYM_W-1:0] pool_sym();
    return {$urandom_range(0, 1) ? 4'hf : 4'h0, 3'($urandom_range(0, 7))};
  endfunction

  task automatic set_mode(input int m);
    idle_pct = (m == 1) ? 85 : (m == 3) ? 6 : 0;
    stall_pct = (m == 2) ? 85 : (m == 3) ? 6 : 0;
  endtask

  task automatic send_item(input logic [CMD_W-1:0] c, input logic [STATE_W-1:0] st,
                           input logic [SYM_W-1:0] sy, input logic [STATE_W-1:0] tg,
                           input logic fl);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    command = c;
    state_index = st;
    symbol = sy;
    target_state = tg;
    flag = fl;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_item(c, st, sy, tg, fl);
    items_sent++;
  endtask

  task automatic set_trans(input logic [STATE_W-1:0] st, input logic [SYM_W-1:0] sy,
                           input logic [STATE_W-1:0] tg, input logic fl);
    send_item(CMD_SET_TRANS, st, sy, tg, fl);
  endtask

  task automatic set_accept(input logic [STATE_W-1:0] st, input logic fl);
    send_item(CMD_SET_ACCEPT, st, SYM_W'($urandom), STATE_W'($urandom), fl);
  endtask

  task automatic scan_char(input logic [SYM_W-1:0] sy);
    send_item(CMD_SCAN, STATE_W'($urandom), sy, STATE_W'($urandom), 1'($urandom));
  endtask

  task automatic end_word();
    send_item(CMD_END, STATE_W'($urandom), SYM_W'($urandom), STATE_W'($urandom),
              1'($urandom));
  endtask

  // lower valid, then wait for every pending result and the pipeline to settle
  task automatic quiesce();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_start(input logic [STATE_W-1:0] v);
    @(negedge clk);
    cfg_data = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.start_st = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [CMD_W-1:0] CMD_CMD_PICK();
    return $urandom_range(0, 1) ? CMD_SET_ACCEPT : CMD_SET_TRANS;
  endfunction

  task automatic random_load();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15)
      send_item(CMD_CMD_PICK(), STATE_W'($urandom), SYM_W'($urandom), STATE_W'($urandom),
                1'($urandom));
    else if (r < 80)
      set_trans(pool_state(), pool_sym(), pool_state(), $urandom_range(0, 99) < 80);
    else
      set_accept(pool_state(), $urandom_range(0, 99) < 65);
  endtask

  // mostly words that stay clear of errors, steered by the tracked automaton
  task automatic random_item();
    int r;
    logic [SYM_W-1:0] direct [$];
    logic [SYM_W-1:0] retry [$];
    for (int s = 0; s < (1 << SYM_W); s++) begin
      if (sb.trans[{sb.cur, SYM_W'(s)}].valid)
        direct.insert(direct.size(), SYM_W'(s));
      else if (!sb.tok_empty && sb.acc[sb.cur] && sb.trans[{sb.start_st, SYM_W'(s)}].valid)
        retry.insert(retry.size(), SYM_W'(s));
    end
    r = $urandom_range(0, 99);
    if (r < 22)
      random_load();
    else if (sb.acc[sb.cur] && (r < 34 || (direct.size() == 0 && retry.size() == 0)))
      end_word();
    else if (retry.size() != 0 && (r < 50 || direct.size() == 0))
      scan_char(retry[$urandom_range(0, retry.size() - 1)]);
    else if (direct.size() != 0)
      scan_char(direct[$urandom_range(0, direct.size() - 1)]);
    else if ($urandom_range(0, 1))
      set_accept(sb.cur, 1'b1);
    else
      set_trans(sb.cur, pool_sym(), pool_state(), 1'b1);
  endtask

  initial begin
    logic [STATE_W-1:0] sv;
    set_mode(0);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    write_start('0);

    // directed: field extremes, retry, end of word, end with empty token
    set_trans(6'd0, 7'd0, 6'd1, 1'b1);
    set_trans(6'd1, 7'd127, 6'd63, 1'b1);
    set_trans(6'd63, 7'd0, 6'd63, 1'b1);
    set_trans(6'd0, 7'd127, 6'd1, 1'b1);
    set_accept(6'd63, 1'b1);
    set_accept(6'd1, 1'b1);
    set_trans(6'd5, 7'd5, 6'd2, 1'b1);
    set_trans(6'd5, 7'd5, 6'd0, 1'b0);
    scan_char(7'd0);
    scan_char(7'd127);
    scan_char(7'd0);
    scan_char(7'd0);
    scan_char(7'd127);
    end_word();
    set_accept(6'd0, 1'b1);
    end_word();
    end_word();
    set_accept(6'd0, 1'b0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      quiesce();
      case (p)
        0, 4: sv = 6'd63;
        1, 5: sv = 6'd0;
        2: sv = 6'd56;
        3: sv = 6'd7;
        6: sv = pool_state();
        default: sv = STATE_W'($urandom);
      endcase
      write_start(sv);
      set_mode(p % 4);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == 60 && p % 2 == 0) quiesce();
        random_item();
      end
    end

    // force a failed retry, then check that the error sticks
    quiesce();
    set_mode(3);
    set_accept(sb.cur, 1'b1);
    end_word();
    set_trans(sb.start_st, 7'd1, 6'd33, 1'b1);
    set_accept(6'd33, 1'b1);
    set_trans(6'd33, 7'd2, 6'd0, 1'b0);
    set_trans(sb.start_st, 7'd2, 6'd0, 1'b0);
    scan_char(7'd1);
    scan_char(7'd2);
    for (int i = 0; i < 30; i++)
      send_item(CMD_W'($urandom), STATE_W'($urandom), SYM_W'($urandom), STATE_W'($urandom),
                1'($urandom));

    quiesce();
    repeat (20) @(posedge clk);
    if (sb.pending.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", sb.pending.size()));
    $display("covered %0d input transactions and %0d results over %0d start states,",
             items_sent, results_seen, NUM_PHASES + 1);
    $display("  four flow-control mixes, and a final sticky error stretch");
    if (mismatches == 0) begin
      $display("tb_dfa_maximal_munch_tokenizer_core: done, clean");
    end else begin
      $display("tb_dfa_maximal_munch_tokenizer_core: done, errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout waiting for transactions");
    $display("tb_dfa_maximal_munch_tokenizer_core: done, errors");
    $finish;
  end

endmodule

@@ sim.f @@
src/dmt_pkg.sv
src/dmt_state_mem.sv
src/dmt_out_fifo.sv
src/dfa_maximal_munch_tokenizer_core.sv
tb/tb_dfa_maximal_munch_tokenizer_core.sv
